[design/abct_pkg.sv]
// Package for the allocation break counter table.
// Holds field widths, parameter defaults, command codes, controller states and the
// command and status structs shared by the controller, the datapath and the top level.
package abct_pkg;

   // fixed field widths of the channels
   localparam int KEY_W  = 32;
   localparam int THR_W  = 16;
   localparam int SIZE_W = 32;
   localparam int CMD_W  = 2;

   // parameter defaults
   localparam int DEF_ENTRIES  = 128;
   localparam int DEF_KEY_BITS = 32;

   localparam logic [THR_W-1:0] HITS_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_CHECK = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_SHIFT,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // latch the request, restart the scan
      logic scan;         // read the next entry while any remain
      logic stop_on_hit;  // freeze the scan on a key match
      logic hit_act;      // record the match; update the entry on set or check
      logic miss_act;     // key absent: append on set
      logic shift_wr;     // move the entry just read down by one
      logic dec_count;    // one entry removed
      logic clear_all;    // empty the table
      logic brk_fire;     // break-every check
      logic emit;         // load the response register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type op;
      logic    key_zero;
      logic    brk;
      logic    hit;
      logic    drained;
   } dp_status_type;

endpackage

[design/abct_if.sv]
// Channel interfaces of the allocation break counter table: request, response and
// register write. Payload widths come from abct_pkg.
interface abct_req_if;
   logic                            valid;
   logic                            ready;
   logic [abct_pkg::CMD_W-1:0]      cmd;
   logic [abct_pkg::KEY_W-1:0]      key;
   logic [abct_pkg::THR_W-1:0]      threshold;
   logic [abct_pkg::SIZE_W-1:0]     alloc_size;

   modport source (output valid, cmd, key, threshold, alloc_size, input ready);
   modport sink   (input valid, cmd, key, threshold, alloc_size, output ready);
endinterface

interface abct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            fire;
   logic [abct_pkg::KEY_W-1:0]      fire_key;
   logic [abct_pkg::THR_W-1:0]      fire_count;
   logic [abct_pkg::SIZE_W-1:0]     fire_size;
   logic                            found;
   logic                            table_full;

   modport source (output valid, fire, fire_key, fire_count, fire_size, found, table_full,
                   input ready);
   modport sink   (input valid, fire, fire_key, fire_count, fire_size, found, table_full,
                   output ready);
endinterface

interface abct_csr_if;
   logic valid;
   logic ready;
   logic break_every;

   modport source (output valid, break_every, input ready);
   modport sink   (input valid, break_every, output ready);
endinterface

[design/allocation_break_counter_table_unit.sv]
// Channel      Dir  Transfer when        Carries
// req_chan     in   valid && ready       cmd, key, threshold, alloc_size
// rsp_chan     out  valid && ready       fire, fire_key, fire_count, fire_size, found,
//                                        table_full
// csr_chan     in   valid (always ready) break_every
//
// One item at a time. Clear-all, break-every check and the unused command go from dispatch
// straight to the response; set, check and clear of a single key also search the table,
// which reads one entry per cycle from the entry memory, and a clear then shifts each
// later entry down at one per cycle.
// Reset empties the table at once; no clearing pass. A waiting response does not block
// the next request, only the following response.
// Top level: instantiates abct_ctrl and abct_dpath; uses abct_pkg and the abct_if channels.
module allocation_break_counter_table_unit #(
   parameter int ENTRIES  = abct_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = abct_pkg::DEF_KEY_BITS
) (
   input  logic        clock,
   input  logic        reset,
   abct_req_if.sink    req_chan,
   abct_rsp_if.source  rsp_chan,
   abct_csr_if.sink    csr_chan
);

   abct_pkg::ctl_cmd_type   ctl;
   abct_pkg::dp_status_type status;

   assign csr_chan.ready = 1'b1;

   abct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctl       (ctl)
   );

   abct_dpath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .status          (status),
      .req_cmd         (req_chan.cmd),
      .req_key         (req_chan.key),
      .req_threshold   (req_chan.threshold),
      .req_alloc_size  (req_chan.alloc_size),
      .csr_write       (csr_chan.valid),
      .csr_break_every (csr_chan.break_every),
      .rsp_fire        (rsp_chan.fire),
      .rsp_fire_key    (rsp_chan.fire_key),
      .rsp_fire_count  (rsp_chan.fire_count),
      .rsp_fire_size   (rsp_chan.fire_size),
      .rsp_found       (rsp_chan.found),
      .rsp_table_full  (rsp_chan.table_full)
   );

`ifndef SYNTH
   // one request in flight: ready drops right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while another is in progress");

   // never overwrite a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response register overwritten");

   // a hit always has a compared entry, so the scan cannot be drained at the same time
   a_hit_not_drained: assert property (@(posedge clock) disable iff (reset)
      ctl.scan && status.hit |-> !status.drained)
      else $error("search hit and drained together");

   // a response is emitted only while a request is in progress
   a_emit_needs_item: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> !req_chan.ready)
      else $error("response emitted with no request in progress");
`endif

endmodule

[design/abct_ctrl.sv]
// Controller of the allocation break counter table: sequences dispatch, table
// search, compaction and response. Uses abct_pkg command/status structs and states.
module abct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  abct_pkg::dp_status_type status,
   output abct_pkg::ctl_cmd_type   ctl
);

   abct_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         abct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = abct_pkg::ST_DISPATCH;
            end
         end
         abct_pkg::ST_DISPATCH: begin
            case (status.op)
               abct_pkg::CMD_SET: begin
                  state_in = abct_pkg::ST_SEARCH;
               end
               abct_pkg::CMD_CLEAR: begin
                  if (status.key_zero) begin
                     ctl.clear_all = 1'b1;
                     state_in      = abct_pkg::ST_DONE;
                  end else begin
                     state_in = abct_pkg::ST_SEARCH;
                  end
               end
               abct_pkg::CMD_CHECK: begin
                  if (status.brk) begin
                     ctl.brk_fire = 1'b1;
                     state_in     = abct_pkg::ST_DONE;
                  end else begin
                     state_in = abct_pkg::ST_SEARCH;
                  end
               end
               default: begin
                  state_in = abct_pkg::ST_DONE;
               end
            endcase
         end
         abct_pkg::ST_SEARCH: begin
            ctl.scan        = 1'b1;
            ctl.stop_on_hit = 1'b1;
            if (status.hit) begin
               ctl.hit_act = 1'b1;
               state_in    = (status.op == abct_pkg::CMD_CLEAR) ? abct_pkg::ST_SHIFT
                                                                 : abct_pkg::ST_DONE;
            end else if (status.drained) begin
               ctl.miss_act = 1'b1;
               state_in     = abct_pkg::ST_DONE;
            end
         end
         abct_pkg::ST_SHIFT: begin
            // close the gap left by the removed entry
            ctl.scan     = 1'b1;
            ctl.shift_wr = 1'b1;
            if (status.drained) begin
               ctl.dec_count = 1'b1;
               state_in      = abct_pkg::ST_DONE;
            end
         end
         abct_pkg::ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = abct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abct_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/abct_dpath.sv]
// Datapath of the allocation break counter table: entry memory, scan pointers,
// hit counter update, entry count, break_every register and response register.
// Uses abct_pkg for widths, command codes and the command/status structs.
module abct_dpath #(
   parameter int ENTRIES  = abct_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = abct_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  abct_pkg::ctl_cmd_type         ctl,
   output abct_pkg::dp_status_type       status,
   input  logic [abct_pkg::CMD_W-1:0]    req_cmd,
   input  logic [abct_pkg::KEY_W-1:0]    req_key,
   input  logic [abct_pkg::THR_W-1:0]    req_threshold,
   input  logic [abct_pkg::SIZE_W-1:0]   req_alloc_size,
   input  logic                          csr_write,
   input  logic                          csr_break_every,
   output logic                          rsp_fire,
   output logic [abct_pkg::KEY_W-1:0]    rsp_fire_key,
   output logic [abct_pkg::THR_W-1:0]    rsp_fire_count,
   output logic [abct_pkg::SIZE_W-1:0]   rsp_fire_size,
   output logic                          rsp_found,
   output logic                          rsp_table_full
);

   localparam int SKEY_W = (KEY_BITS < abct_pkg::KEY_W) ? KEY_BITS : abct_pkg::KEY_W;
   localparam int THR_W  = abct_pkg::THR_W;
   localparam int ENT_W  = SKEY_W + 2 * THR_W;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   // entry layout: key | threshold | hits
   logic [ENT_W-1:0]  mem [ENTRIES];

   abct_pkg::cmd_type           op_ff;
   logic [SKEY_W-1:0]           key_ff;
   logic [THR_W-1:0]            thr_ff;
   logic [abct_pkg::SIZE_W-1:0] size_ff;
   logic                        brk_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            issue_ff, issue_in;
   logic                        cmp_vld_ff;
   logic [IDX_W-1:0]            cmp_idx_ff;
   logic [ENT_W-1:0]            rd_data_ff;
   logic                        found_ff, full_ff, fire_ff;
   logic [THR_W-1:0]            fcount_ff;

   logic [SKEY_W-1:0]           rd_key;
   logic [THR_W-1:0]            rd_thr, rd_hits;
   logic                        more, hit, issue, tab_full;
   logic [THR_W:0]              hit_sum;
   logic [THR_W-1:0]            hit_sat;
   logic                        check_fire;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [ENT_W-1:0]            wr_data;

   assign rd_key  = rd_data_ff[ENT_W-1 -: SKEY_W];
   assign rd_thr  = rd_data_ff[2*THR_W-1 -: THR_W];
   assign rd_hits = rd_data_ff[THR_W-1:0];

   assign more     = issue_ff < count_ff;
   assign hit      = cmp_vld_ff && (rd_key == key_ff);
   assign issue    = ctl.scan && more && !(ctl.stop_on_hit && hit);
   assign tab_full = count_ff == CNT_W'(ENTRIES);

   assign hit_sum    = {1'b0, rd_hits} + (THR_W + 1)'(1);
   assign hit_sat    = hit_sum[THR_W] ? abct_pkg::HITS_MAX : hit_sum[THR_W-1:0];
   assign check_fire = hit_sat >= rd_thr;

   assign status.op       = op_ff;
   assign status.key_zero = (key_ff == '0);
   assign status.brk      = brk_ff;
   assign status.hit      = hit;
   assign status.drained  = !cmp_vld_ff && !more;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmp_idx_ff;
      wr_data = rd_data_ff;
      if (ctl.hit_act && op_ff == abct_pkg::CMD_SET) begin
         wr_en   = 1'b1;
         wr_data = {rd_key, thr_ff, rd_hits};
      end else if (ctl.hit_act && op_ff == abct_pkg::CMD_CHECK) begin
         wr_en   = 1'b1;
         wr_data = {rd_key, rd_thr, check_fire ? {THR_W{1'b0}} : hit_sat};
      end else if (ctl.miss_act && op_ff == abct_pkg::CMD_SET && !tab_full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = {key_ff, thr_ff, {THR_W{1'b0}}};
      end else if (ctl.shift_wr && cmp_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = cmp_idx_ff - IDX_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.clear_all) begin
         count_in = '0;
      end else if (ctl.miss_act && op_ff == abct_pkg::CMD_SET && !tab_full) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
      issue_in = issue_ff;
      if (ctl.load) begin
         issue_in = '0;
      end else if (issue) begin
         issue_in = issue_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
         cmp_idx_ff <= issue_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         issue_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         brk_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= issue;
         if (csr_write) begin
            brk_ff <= csr_break_every;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff     <= abct_pkg::cmd_type'(req_cmd);
         key_ff    <= req_key[SKEY_W-1:0];
         thr_ff    <= req_threshold;
         size_ff   <= req_alloc_size;
         found_ff  <= 1'b0;
         full_ff   <= 1'b0;
         fire_ff   <= 1'b0;
         fcount_ff <= '0;
      end else begin
         if (ctl.brk_fire) begin
            fire_ff   <= 1'b1;
            fcount_ff <= THR_W'(1);
         end
         if (ctl.hit_act) begin
            found_ff <= 1'b1;
            if (op_ff == abct_pkg::CMD_CHECK && check_fire) begin
               fire_ff   <= 1'b1;
               fcount_ff <= hit_sat;
            end
         end
         if (ctl.miss_act && op_ff == abct_pkg::CMD_SET && tab_full) begin
            full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_fire       <= fire_ff;
         rsp_fire_key   <= fire_ff ? abct_pkg::KEY_W'(key_ff) : '0;
         rsp_fire_count <= fcount_ff;
         rsp_fire_size  <= fire_ff ? size_ff : '0;
         rsp_found      <= found_ff;
         rsp_table_full <= full_ff;
      end
   end

endmodule
